@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the table logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SIT_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SIT_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SIT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sit_pkg.sv @@
package sit_pkg;

	localparam int MAX_RANGES_DEF = 16;
	localparam int ADDR_W         = 64;
	localparam int IDX_W          = 4;
	localparam int CNT_W          = 5;
	localparam int STAT_W         = 3;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_OVERLAP   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;

	typedef enum logic [1:0] {
		CLS_INSERT,
		CLS_READ,
		CLS_EMPTY
	} cls_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
		logic [IDX_W-1:0]  entry_index;
	} sit_in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  entry_count;
		logic [ADDR_W-1:0] read_start;
		logic [ADDR_W-1:0] read_end;
	} sit_out_t;

	typedef struct packed {
		cls_t              cls;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
		logic [IDX_W-1:0]  entry_index;
	} q_entry_t;

endpackage

@@ rtl/sit_front.sv @@
`include "assert_macros.svh"

module sit_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sit_pkg::sit_in_t  in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output sit_pkg::q_entry_t q_data
);

	localparam int QD = sit_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	sit_pkg::q_entry_t entry_q [QD];
	sit_pkg::q_entry_t cls_entry;
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              push;
	logic              pop;

	always_comb begin
		cls_entry.start_addr  = in_data.start_addr;
		cls_entry.end_addr    = in_data.end_addr;
		cls_entry.entry_index = in_data.entry_index;
		priority if (in_data.op == sit_pkg::OP_READ) begin
			cls_entry.cls = sit_pkg::CLS_READ;
		end else if (in_data.end_addr <= in_data.start_addr) begin
			cls_entry.cls = sit_pkg::CLS_EMPTY;
		end else begin
			cls_entry.cls = sit_pkg::CLS_INSERT;
		end
	end

	assign in_ready = (cnt_q != CW'(QD));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`SIT_ASSERT_ALWAYS(a_queue_bound, clk, arst_n, cnt_q <= CW'(QD), "queue count exceeds depth")

endmodule

@@ rtl/sit_table.sv @@
`include "assert_macros.svh"

module sit_table #(
	parameter int MAX_RANGES = sit_pkg::MAX_RANGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  sit_pkg::q_entry_t q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sit_pkg::sit_out_t out_data
);

	localparam int AW   = sit_pkg::ADDR_W;
	localparam int IW   = sit_pkg::IDX_W;
	localparam int OCW  = sit_pkg::CNT_W;
	localparam int CW   = $clog2(MAX_RANGES + 1);
	localparam int RD_N = (MAX_RANGES < (2 ** IW)) ? MAX_RANGES : (2 ** IW);

	typedef enum logic {
		S_LOOK,
		S_COMMIT
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     starts_q [MAX_RANGES];
	logic [AW-1:0]     ends_q   [MAX_RANGES];
	logic [MAX_RANGES-1:0] valid_q;
	logic [CW-1:0]     count_q;

	logic [MAX_RANGES-1:0] gt;
	logic [MAX_RANGES-1:0] ov;
	logic              rd_ok;
	logic [AW-1:0]     rd_start;
	logic [AW-1:0]     rd_end;

	sit_pkg::cls_t     cls_s2;
	logic [AW-1:0]     start_s2;
	logic [AW-1:0]     end_s2;
	logic [MAX_RANGES-1:0] gt_s2;
	logic [MAX_RANGES-1:0] ov_s2;
	logic              rd_ok_s2;
	logic [AW-1:0]     rd_start_s2;
	logic [AW-1:0]     rd_end_s2;

	logic [MAX_RANGES-1:0] above;
	logic [MAX_RANGES-1:0] take_new;
	logic              ov_any;
	logic              full;
	logic              out_free;
	logic              commit;
	logic              do_ins;
	logic              lookup;
	logic [CW-1:0]     cnt_new;
	sit_pkg::sit_out_t res;
	sit_pkg::sit_out_t out_q;
	logic              out_valid_q;

	assign q_ready  = (state_q == S_LOOK);
	assign lookup   = q_valid && q_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == S_COMMIT) && out_free;
	assign ov_any   = |ov_s2;
	assign full     = valid_q[MAX_RANGES-1];
	assign do_ins   = commit && (cls_s2 == sit_pkg::CLS_INSERT) && !ov_any && !full;
	assign cnt_new  = do_ins ? count_q + CW'(1) : count_q;
	assign above    = gt_s2 | ~valid_q;

	always_comb begin
		gt       = '0;
		ov       = '0;
		rd_ok    = 1'b0;
		rd_start = '0;
		rd_end   = '0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			gt[i] = valid_q[i] && (starts_q[i] > q_data.start_addr);
			ov[i] = valid_q[i] && (starts_q[i] < q_data.end_addr)
				&& (ends_q[i] > q_data.start_addr);
		end
		for (int i = 0; i < RD_N; i++) begin
			if ((q_data.entry_index == IW'(i)) && valid_q[i]) begin
				rd_ok    = 1'b1;
				rd_start = starts_q[i];
				rd_end   = ends_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup) begin
			cls_s2      <= q_data.cls;
			start_s2    <= q_data.start_addr;
			end_s2      <= q_data.end_addr;
			gt_s2       <= gt;
			ov_s2       <= ov;
			rd_ok_s2    <= rd_ok;
			rd_start_s2 <= rd_start;
			rd_end_s2   <= rd_end;
		end
	end

	always_comb begin
		res.entry_count = OCW'(cnt_new);
		res.read_start  = '0;
		res.read_end    = '0;
		unique case (cls_s2)
			sit_pkg::CLS_EMPTY: begin
				res.status = sit_pkg::ST_EMPTY;
			end
			sit_pkg::CLS_READ: begin
				if (rd_ok_s2) begin
					res.status     = sit_pkg::ST_READ_OK;
					res.read_start = rd_start_s2;
					res.read_end   = rd_end_s2;
				end else begin
					res.status = sit_pkg::ST_BAD_INDEX;
				end
			end
			sit_pkg::CLS_INSERT: begin
				priority if (ov_any) begin
					res.status = sit_pkg::ST_OVERLAP;
				end else if (full) begin
					res.status = sit_pkg::ST_FULL;
				end else begin
					res.status = sit_pkg::ST_INSERTED;
				end
			end
			default: begin
				res.status = sit_pkg::ST_EMPTY;
			end
		endcase
	end

	for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign take_new[g] = above[g];
			always_ff @(posedge clk) begin
				if (do_ins && take_new[g]) begin
					starts_q[g] <= start_s2;
					ends_q[g]   <= end_s2;
				end
			end
		end else begin : g_rest
			assign take_new[g] = above[g] && !above[g-1];
			always_ff @(posedge clk) begin
				if (do_ins && take_new[g]) begin
					starts_q[g] <= start_s2;
					ends_q[g]   <= end_s2;
				end else if (do_ins && above[g]) begin
					starts_q[g] <= starts_q[g-1];
					ends_q[g]   <= ends_q[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (do_ins) begin
			valid_q <= {valid_q[MAX_RANGES-2:0], 1'b1};
			count_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOOK;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOOK: begin
					if (q_valid) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_LOOK;
					end
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SIT_ASSERT_ALWAYS(a_valid_prefix, clk, arst_n, (valid_q & (valid_q + MAX_RANGES'(1))) == '0, "valid cells not a prefix")
	`SIT_ASSERT_ALWAYS(a_count_match, clk, arst_n, count_q == CW'($countones(valid_q)), "count disagrees with valid cells")
	`SIT_ASSERT_NEXT(a_insert_count, clk, arst_n, do_ins, count_q == $past(count_q) + CW'(1), "insert did not bump count")

	for (genvar g = 0; g < MAX_RANGES - 1; g++) begin : g_chk
		`SIT_ASSERT_IMPLY(a_sorted, clk, arst_n, valid_q[g+1], (starts_q[g] < ends_q[g]) && (ends_q[g] <= starts_q[g+1]), "table order broken")
	end

endmodule

@@ rtl/sorted_interval_table_unit.sv @@
// Sorted interval table: holds up to MAX_RANGES half-open ranges [start,end),
// ordered by start and never overlapping.
// Input channel in_valid/in_ready/in_data: op 0 inserts [start_addr,end_addr),
// op 1 reads the entry at sorted position entry_index.
// Output channel out_valid/out_ready/out_data: exactly one result per request,
// in request order, with status, entry count after the request, and the range
// read (zero unless the read succeeded).
// A request passes the queue, the engine's lookup registers and the output
// register before its result is presented.
// The table engine handles one request at a time: it compares all cells in its
// look state and commits (status, shift, write) in its commit state.
// A two-entry queue in front classifies requests and lets the input side keep
// accepting while the engine works or the output waits.
// Reset: the table empties at once; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, the
// engine waits, and the queue fills; in_ready drops once the queue is full.
module sorted_interval_table_unit #(
	parameter int MAX_RANGES = sit_pkg::MAX_RANGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sit_pkg::sit_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sit_pkg::sit_out_t out_data
);

	logic              q_valid;
	logic              q_ready;
	sit_pkg::q_entry_t q_data;

	sit_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	sit_table #(
		.MAX_RANGES (MAX_RANGES)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ dv/sorted_interval_table_checker.sv @@
`timescale 1ns / 1ps

module sorted_interval_table_checker
	import sit_pkg::*;
#(
	parameter int TABLE_DEPTH = MAX_RANGES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  sit_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  sit_out_t out_data,
	output int       mismatches,
	output int       outstanding
);

	logic [ADDR_W-1:0] table_starts [TABLE_DEPTH];
	logic [ADDR_W-1:0] table_ends   [TABLE_DEPTH];
	int                ranges_held;
	sit_out_t          awaited_outcomes [$];

	task automatic report(input string field, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	function automatic sit_out_t apply_request(input sit_in_t req);
		sit_out_t res;
		int pos;
		int k;
		res = '0;
		if (req.op == OP_INSERT) begin
			if (req.end_addr <= req.start_addr) begin
				res.status = ST_EMPTY;
			end else begin
				pos = 0;
				while (pos < ranges_held && table_starts[pos] <= req.start_addr)
					pos++;
				if (pos > 0 && table_ends[pos - 1] > req.start_addr) begin
					res.status = ST_OVERLAP;
				end else if (pos < ranges_held && req.end_addr > table_starts[pos]) begin
					res.status = ST_OVERLAP;
				end else if (ranges_held >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (k = ranges_held; k > pos; k--) begin
						table_starts[k] = table_starts[k - 1];
						table_ends[k]   = table_ends[k - 1];
					end
					table_starts[pos] = req.start_addr;
					table_ends[pos]   = req.end_addr;
					ranges_held++;
					res.status = ST_INSERTED;
				end
			end
		end else if (int'(req.entry_index) < ranges_held) begin
			res.status     = ST_READ_OK;
			res.read_start = table_starts[req.entry_index];
			res.read_end   = table_ends[req.entry_index];
		end else begin
			res.status = ST_BAD_INDEX;
		end
		res.entry_count = CNT_W'(ranges_held);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sit_out_t want;
		if (!arst_n) begin
			ranges_held = 0;
			mismatches  = 0;
			awaited_outcomes.delete();
		end else begin
			if (in_valid && in_ready)
				awaited_outcomes.push_back(apply_request(in_data));
			if (out_valid && out_ready) begin
				if (awaited_outcomes.size() == 0) begin
					report("status of unrequested transaction", out_data.status, '0);
				end else begin
					want = awaited_outcomes.pop_front();
					if (out_data.status !== want.status)
						report("status", out_data.status, want.status);
					if (out_data.entry_count !== want.entry_count)
						report("entry_count", out_data.entry_count, want.entry_count);
					if (out_data.read_start !== want.read_start)
						report("read_start", out_data.read_start, want.read_start);
					if (out_data.read_end !== want.read_end)
						report("read_end", out_data.read_end, want.read_end);
				end
			end
		end
		outstanding = awaited_outcomes.size();
	end

endmodule

@@ dv/sorted_interval_table_unit_tb.sv @@
`timescale 1ns / 1ps

module sorted_interval_table_unit_tb;
	import sit_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS   = 80;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sit_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	sit_out_t out_data;
	int       mismatches;
	int       outstanding;

	int  send_gap_odds;
	int  stall_odds;
	int  stall_left;
	bit  calm;
	logic [ADDR_W-1:0] tried_lo [$];
	logic [ADDR_W-1:0] tried_hi [$];

	sorted_interval_table_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	sorted_interval_table_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!calm && stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ADDR_W-1:0] rand_len();
		case ($urandom_range(0, 3))
			0, 1:    return ADDR_W'($urandom_range(1, 300));
			2:       return {32'h0, $urandom};
			default: return {$urandom >> 2, $urandom};
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] end_after(input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] len);
		logic [ADDR_W:0] sum;
		sum = {1'b0, lo} + len;
		return sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
	endfunction

	task automatic send(input sit_in_t req);
		int gap;
		if (!calm && send_gap_odds != 0 && $urandom_range(0, send_gap_odds - 1) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_insert(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		sit_in_t req;
		req.op          = OP_INSERT;
		req.start_addr  = lo;
		req.end_addr    = hi;
		req.entry_index = IDX_W'($urandom);
		tried_lo.push_back(lo);
		tried_hi.push_back(hi);
		send(req);
	endtask

	task automatic send_read(input int idx);
		sit_in_t req;
		req.op          = OP_READ;
		req.start_addr  = rand_addr();
		req.end_addr    = rand_addr();
		req.entry_index = IDX_W'(idx);
		send(req);
	endtask

	task automatic random_insert();
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		int pick;
		pick = $urandom_range(0, tried_lo.size() - 1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				lo = rand_addr();
				hi = end_after(lo, rand_len());
			end
			5: begin
				lo = tried_lo[pick];
				hi = end_after(lo, rand_len());
			end
			6: begin
				lo = tried_lo[pick] + $urandom_range(1, 300);
				hi = end_after(lo, rand_len());
			end
			7: begin
				if ($urandom_range(0, 1)) begin
					lo = tried_hi[pick];
					hi = end_after(lo, rand_len());
				end else begin
					hi = tried_lo[pick];
					lo = hi - $urandom_range(1, 300);
				end
			end
			8: begin
				lo = rand_addr();
				hi = $urandom_range(0, 1) ? rand_addr() : lo - $urandom_range(0, 3);
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					lo = ADDR_W'($urandom_range(0, 300));
					hi = end_after(lo, rand_len());
				end else begin
					hi = '1 - $urandom_range(0, 300);
					lo = hi - rand_len();
				end
			end
		endcase
		send_insert(lo, hi);
	endtask

	initial begin
		int n;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		calm          = 1'b0;
		send_gap_odds = 0;
		stall_odds    = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_read(0);
		send_insert('0, '0);
		send_insert('1, '1);
		send_insert('1, '0);
		send_insert(64'd1000, 64'd2000);
		send_insert(64'd2000, 64'd3000);
		send_insert(64'd500, 64'd1000);
		send_insert(64'd1000, 64'd1500);
		send_insert(64'd1500, 64'd2500);
		send_insert(64'd0, 64'd501);
		send_insert(64'd0, 64'd16);
		send_insert('1 - 64'd16, '1);
		send_insert(64'd2999, 64'd3001);
		send_insert(64'd16, 64'd500);
		send_insert('1 - 64'd16, '1);
		send_read(0);
		send_read(3);
		send_read(6);
		send_read(7);
		send_read(15);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       send_gap_odds = 0;
					1:       send_gap_odds = 3;
					default: send_gap_odds = 10;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_odds = 0;
					1:       stall_odds = 4;
					default: stall_odds = 12;
				endcase
			end
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if ($urandom_range(0, 9) < 3)
				random_insert();
			else
				send_read($urandom_range(0, 15));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_front.sv
rtl/sit_table.sv
rtl/sorted_interval_table_unit.sv
dv/sorted_interval_table_checker.sv
dv/sorted_interval_table_unit_tb.sv
